### sv/assert_macros.svh
// Assertion macros used by the filter controller RTL.
// Define SYNTH to compile the checks away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock, masked while reset is high.
`define FIRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock, including during reset.
`define FIRI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FIRI_ASSERT(lbl, prop, msg)
`define FIRI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/firi_pkg.sv
// Shared types and constants for the iterative FIR filter.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package firi_pkg;

  localparam int COEF_BITS = 16;
  localparam int OUT_BITS  = 38;
  localparam int IDX_BITS  = 6;
  localparam int CFG_BITS  = 7;
  localparam int FUNC_BITS = 2;

  // Transaction function codes
  localparam logic [FUNC_BITS-1:0] FUNC_FILTER  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd2;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DONE  = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // write one coefficient
    logic restart;  // empty the delay line
    logic push;     // store a new sample and arm the tap walk
    logic issue;    // read one tap into the MAC pipeline
    logic publish;  // copy the accumulator to the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic taps_done;   // every active tap has been issued
    logic pipe_empty;  // no tap is in flight in the MAC pipeline
  } status_t;

endpackage

### sv/firi_if.sv
// Valid/ready channel interfaces for filter input and result transactions.
// Depends on firi_pkg for field widths.
`timescale 1ns / 1ps

interface firi_in_if #(parameter int SAMPLE_BITS = 16);
  logic                                  valid;
  logic                                  ready;
  logic [firi_pkg::FUNC_BITS-1:0]        func;
  logic signed [SAMPLE_BITS-1:0]         sample;
  logic [firi_pkg::IDX_BITS-1:0]         coef_index;
  logic signed [firi_pkg::COEF_BITS-1:0] coef_value;

  modport source (output valid, func, sample, coef_index, coef_value, input ready);
  modport sink (input valid, func, sample, coef_index, coef_value, output ready);
endinterface

interface firi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [firi_pkg::OUT_BITS-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink (input valid, filtered, output ready);
endinterface

### sv/firi_ctrl.sv
// Controller state machine for the iterative FIR filter: handshakes and sequencing.
// Depends on firi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module firi_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [firi_pkg::FUNC_BITS-1:0] in_func,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output firi_pkg::cmd_t                 cmd,
  input  firi_pkg::status_t              status
);

  firi_pkg::state_t state, state_next;
  logic             accept;
  logic             out_free;

  assign in_ready = (state == firi_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Decode commands
  always_comb begin
    cmd         = '0;
    cmd.load    = accept && (in_func == firi_pkg::FUNC_LOAD);
    cmd.restart = accept && (in_func == firi_pkg::FUNC_RESTART);
    cmd.push    = accept && (in_func == firi_pkg::FUNC_FILTER);
    cmd.issue   = (state == firi_pkg::ST_ISSUE) && !status.taps_done;
    cmd.publish = (state == firi_pkg::ST_DONE) && out_free;
  end

  // Sequence one filter transaction
  always_comb begin
    state_next = state;
    case (state)
      firi_pkg::ST_IDLE: begin
        if (cmd.push) state_next = firi_pkg::ST_ISSUE;
      end
      firi_pkg::ST_ISSUE: begin
        if (status.taps_done) state_next = firi_pkg::ST_DRAIN;
      end
      firi_pkg::ST_DRAIN: begin
        if (status.pipe_empty) state_next = firi_pkg::ST_DONE;
      end
      firi_pkg::ST_DONE: begin
        if (out_free) state_next = firi_pkg::ST_IDLE;
      end
      default: state_next = firi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= firi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `FIRI_ASSERT(a_publish_free, cmd.publish |-> (!out_valid || out_ready), "publish over result")
  `FIRI_ASSERT(a_publish_valid, cmd.publish |=> out_valid, "published result not valid")
  `FIRI_ASSERT(a_idle_empty, in_ready |-> status.pipe_empty, "accepting with taps in flight")
  `FIRI_ASSERT(a_issue_bound, cmd.issue |-> !status.taps_done, "tap issued past tap count")

endmodule

### sv/firi_datapath.sv
// Datapath for the iterative FIR filter: tap memories, delay line, shared MAC.
// Depends on firi_pkg; driven by firi_ctrl commands.
`timescale 1ns / 1ps

module firi_datapath #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [firi_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [firi_pkg::IDX_BITS-1:0]         coef_index,
  input  logic signed [firi_pkg::COEF_BITS-1:0] coef_value,
  input  firi_pkg::cmd_t                        cmd,
  output firi_pkg::status_t                     status,
  output logic signed [firi_pkg::OUT_BITS-1:0]  filtered
);

  // Taps beyond the loadable index range always hold zero, so store only those
  localparam int IDX_SPAN  = 1 << firi_pkg::IDX_BITS;
  localparam int TAB_DEPTH = (MAX_TAPS < IDX_SPAN) ? MAX_TAPS : IDX_SPAN;
  localparam int AW        = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int CW        = $clog2(TAB_DEPTH + 1);
  localparam int PROD_W    = SAMPLE_BITS + firi_pkg::COEF_BITS;
  localparam int OW        = firi_pkg::OUT_BITS;

  logic signed [firi_pkg::COEF_BITS-1:0] coef_mem [TAB_DEPTH];
  logic signed [SAMPLE_BITS-1:0]         dly_mem  [TAB_DEPTH];
  logic [TAB_DEPTH-1:0]                  coef_vld;
  logic [firi_pkg::CFG_BITS-1:0]         tap_count;
  logic [AW-1:0]                         wp, wp_next;
  logic [CW-1:0]                         fill;
  logic [CW-1:0]                         n_taps, n_taps_next;
  logic [CW-1:0]                         k;
  logic [AW-1:0]                         rd_idx;
  logic                                  load_ok;
  logic signed [SAMPLE_BITS-1:0]         rd_sample;
  logic signed [firi_pkg::COEF_BITS-1:0] rd_coef;
  logic                                  rd_live;
  logic                                  v1, v2;
  logic signed [PROD_W-1:0]              prod_full;
  logic signed [OW-1:0]                  prod;
  logic signed [OW-1:0]                  acc;

  assign load_ok = ({{(32 - firi_pkg::IDX_BITS){1'b0}}, coef_index} < 32'(TAB_DEPTH));
  assign wp_next = (wp == AW'(TAB_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign n_taps_next = ({{(32 - firi_pkg::CFG_BITS){1'b0}}, tap_count} > 32'(TAB_DEPTH))
                       ? CW'(TAB_DEPTH) : CW'(tap_count);

  assign status.taps_done  = (k == n_taps);
  assign status.pipe_empty = !v1 && !v2;

  // Tap count register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= firi_pkg::CFG_BITS'(1);
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  // Coefficient memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) coef_mem[coef_index[AW-1:0]] <= coef_value;
    if (cmd.issue) rd_coef <= coef_mem[k[AW-1:0]];
  end

  // Delay line memory, circular with wp at the newest sample
  always_ff @(posedge clk) begin
    if (cmd.push) dly_mem[wp_next] <= sample;
    if (cmd.issue) rd_sample <= dly_mem[rd_idx];
  end

  // Written coefficients and delay line fill level; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      wp       <= '0;
      fill     <= '0;
    end else begin
      if (cmd.load && load_ok) coef_vld[coef_index[AW-1:0]] <= 1'b1;
      if (cmd.restart) begin
        fill <= '0;
      end else if (cmd.push) begin
        wp   <= wp_next;
        fill <= (fill == CW'(TAB_DEPTH)) ? fill : fill + 1'b1;
      end
    end
  end

  // Walk the taps: newest sample with tap 0, moving back one sample per tap
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      k      <= '0;
      rd_idx <= wp_next;
      n_taps <= n_taps_next;
    end else if (cmd.issue) begin
      k       <= k + 1'b1;
      rd_idx  <= (rd_idx == '0) ? AW'(TAB_DEPTH - 1) : rd_idx - 1'b1;
      rd_live <= (k < fill) && coef_vld[k[AW-1:0]];
    end
  end

  // MAC pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // Multiply, register, then accumulate modulo the output width
  assign prod_full = rd_sample * rd_coef;

  always_ff @(posedge clk) begin
    if (v1) prod <= rd_live ? OW'(prod_full) : '0;
    if (cmd.push) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
    if (cmd.publish) filtered <= acc;
  end

endmodule

### sv/fir_filter_iterative_core.sv
// Iterative direct-form FIR filter: one shared multiply-accumulate walks the taps.
// Filter transaction: the shared MAC issues n taps, n = min(tap_count, MAX_TAPS, 64), then drains
// its pipeline before the result is published. A new filter transaction is accepted only after
// that result is published, so a result stall also holds the input; load and restart transactions
// are accepted in the idle state and complete without leaving it. Output register frees the input side.
// Reset: tap_count is 1, coefficients and delay line read as zero; no clearing pass.
`timescale 1ns / 1ps

module fir_filter_iterative_core #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [firi_pkg::CFG_BITS-1:0] cfg_wdata,
  firi_in_if.sink                       samples,
  firi_out_if.source                    results
);

  firi_pkg::cmd_t    cmd;
  firi_pkg::status_t status;

  // Sequence transactions
  firi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_func   (samples.func),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Store taps and accumulate
  firi_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sample     (samples.sample),
    .coef_index (samples.coef_index),
    .coef_value (samples.coef_value),
    .cmd        (cmd),
    .status     (status),
    .filtered   (results.filtered)
  );

endmodule
